// ===== rtl/rse_pkg.sv =====
package rse_pkg;

  // configuration port
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORRECT_CNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODE_FORM = 2'd2;

  localparam logic [8:0] FIELD_POLY_RST  = 9'd285;
  localparam logic [3:0] CORRECT_CNT_RST = 4'd8;
  localparam logic       ENCODE_FORM_RST = 1'b0;

  // encode_form values
  localparam logic FORM_SYSTEMATIC = 1'b0;
  localparam logic FORM_PRODUCT    = 1'b1;

  // the operation that every cell of the chain performs
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_GEN,
    CELL_ENC
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_BUILD,
    ST_RUN,
    ST_FLUSH
  } state_t;

endpackage

// ===== rtl/rse_cell.sv =====
module rse_cell
  import rse_pkg::*;
#(
  parameter int SYMBOL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_op_t               op,
  input  logic [SYMBOL_BITS-1:0] taps,
  input  logic [SYMBOL_BITS-1:0] mul_in,
  input  logic [SYMBOL_BITS-1:0] s_in,
  input  logic [SYMBOL_BITS-1:0] g_in,
  output logic [SYMBOL_BITS-1:0] s_out,
  output logic [SYMBOL_BITS-1:0] g_out
);

  function automatic logic [SYMBOL_BITS-1:0] gf_mul(
    input logic [SYMBOL_BITS-1:0] a,
    input logic [SYMBOL_BITS-1:0] b,
    input logic [SYMBOL_BITS-1:0] t
  );
    logic [SYMBOL_BITS-1:0] acc;
    logic [SYMBOL_BITS-1:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < SYMBOL_BITS; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      if (sh[SYMBOL_BITS-1]) begin
        sh = {sh[SYMBOL_BITS-2:0], 1'b0} ^ t;
      end else begin
        sh = {sh[SYMBOL_BITS-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  logic [SYMBOL_BITS-1:0] s_r, s_nxt;
  logic [SYMBOL_BITS-1:0] g_r, g_nxt;
  logic [SYMBOL_BITS-1:0] mul_b;
  logic [SYMBOL_BITS-1:0] prod;

  // one shared multiplier: root times upper coefficient, or the chain input times own coefficient
  assign mul_b = (op == CELL_GEN) ? g_in : g_r;
  assign prod  = gf_mul(mul_in, mul_b, taps);

  always_comb begin
    s_nxt = s_r;
    g_nxt = g_r;
    case (op)
      CELL_HOLD: begin
      end
      CELL_CLEAR: begin
        s_nxt = '0;
        g_nxt = '0;
      end
      CELL_GEN: begin
        g_nxt = g_r ^ prod;
      end
      CELL_ENC: begin
        s_nxt = s_in ^ prod;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      g_r <= '0;
    end else begin
      s_r <= s_nxt;
      g_r <= g_nxt;
    end
  end

  assign s_out = s_r;
  assign g_out = g_r;

endmodule

// ===== rtl/reed_solomon_encoder_core.sv =====
// channel  direction  handshake             payload
// in_      input      in_valid / in_ready   in_message_symbol
// out_     output     out_valid / out_ready out_code_symbol, out_is_parity, out_block_end
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle unless stalled; each is answered in the next cycle by the output register
// the last message item of a block is followed by a flush of 2t parity items, with no input taken
// the generator is built one root per cycle in the cell chain after reset and after
//   every valid configuration write, no input taken meanwhile
// synchronous active-low reset; a valid configuration write clears the cells and aborts the block
// a stall on out_ready holds the output register and blocks the input in the same cycle
module reed_solomon_encoder_core
  import rse_pkg::*;
#(
  parameter int SYMBOL_BITS = 8,
  parameter int MAX_T       = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SYMBOL_BITS-1:0] in_message_symbol,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SYMBOL_BITS-1:0] out_code_symbol,
  output logic                   out_is_parity,
  output logic                   out_block_end,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CODE_LEN = (1 << SYMBOL_BITS) - 1;
  localparam int T_CAP    = (MAX_T < (CODE_LEN - 1) / 2) ? MAX_T : (CODE_LEN - 1) / 2;
  localparam int NCELL    = 2 * MAX_T;
  localparam int P_W      = $clog2(2 * T_CAP + 1);

  localparam logic [SYMBOL_BITS-1:0] ALPHA = SYMBOL_BITS'(2);
  localparam logic [SYMBOL_BITS-1:0] ONE   = SYMBOL_BITS'(1);

  // configuration registers
  logic [8:0] field_poly_r;
  logic [3:0] correct_cnt_r;
  logic       encode_form_r;
  logic       cfg_hit;

  // control
  state_t                 state_r, state_nxt;
  logic [P_W-1:0]         step_cnt_r, step_cnt_nxt;
  logic [SYMBOL_BITS-1:0] root_r, root_nxt;
  logic [SYMBOL_BITS-1:0] sym_cnt_r, sym_cnt_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  logic [SYMBOL_BITS-1:0] out_sym_r;
  logic                   out_par_r;
  logic                   out_end_r;
  logic                   out_load;
  logic [SYMBOL_BITS-1:0] out_sym_d;
  logic                   out_par_d;
  logic                   out_end_d;
  logic                   out_free;

  // derived block geometry
  logic [P_W-1:0]           par_cnt;
  logic [P_W-1:0]           par_last;
  logic [SYMBOL_BITS-1:0]   msg_len;
  logic                     msg_last;
  logic [SYMBOL_BITS+8:0]   poly_wide;
  logic [SYMBOL_BITS-1:0]   taps;
  logic [SYMBOL_BITS:0]     root_sh;
  logic [SYMBOL_BITS-1:0]   root_times_x;

  // cell chain
  cell_op_t               cell_op;
  logic [SYMBOL_BITS-1:0] mul_in;
  logic [SYMBOL_BITS-1:0] s_w [NCELL];
  logic [SYMBOL_BITS-1:0] g_w [NCELL];
  logic [SYMBOL_BITS-1:0] s_top;
  logic                   in_ready_c;
  logic                   in_fire;

  assign cfg_hit = cfg_we && ((cfg_index == REG_FIELD_POLY) || (cfg_index == REG_CORRECT_CNT)
                              || (cfg_index == REG_ENCODE_FORM));

  // reduction taps: low symbol bits of the field polynomial, zero above bit 8
  assign poly_wide = {{SYMBOL_BITS{1'b0}}, field_poly_r};
  assign taps      = poly_wide[SYMBOL_BITS-1:0];

  // parity count 2t with t clamped into its legal range
  always_comb begin
    if (correct_cnt_r == 4'd0) begin
      par_cnt = P_W'(2);
    end else if (int'(correct_cnt_r) > T_CAP) begin
      par_cnt = P_W'(2 * T_CAP);
    end else begin
      par_cnt = P_W'({correct_cnt_r, 1'b0});
    end
  end

  assign par_last = par_cnt - 1'b1;
  assign msg_len  = SYMBOL_BITS'(CODE_LEN) - SYMBOL_BITS'(par_cnt);
  assign msg_last = ({1'b0, sym_cnt_r} + 1'b1) >= {1'b0, msg_len};

  // next root of the generator: multiply by alpha = x
  assign root_sh      = {root_r, 1'b0};
  assign root_times_x = root_sh[SYMBOL_BITS] ? (root_sh[SYMBOL_BITS-1:0] ^ taps)
                                             : root_sh[SYMBOL_BITS-1:0];

  // coefficients sit right-aligned at the top of the chain, so the top cell is always the tap
  assign s_top    = s_w[NCELL-1];
  assign out_free = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready_c;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    logic [SYMBOL_BITS-1:0] s_from_below;
    logic [SYMBOL_BITS-1:0] g_from_above;

    if (c == 0) begin : g_bottom
      assign s_from_below = '0;
    end else begin : g_mid_lo
      assign s_from_below = s_w[c-1];
    end

    // the leading coefficient of the monic generator stands virtually above the top cell
    if (c == NCELL - 1) begin : g_top
      assign g_from_above = ONE;
    end else begin : g_mid_hi
      assign g_from_above = g_w[c+1];
    end

    rse_cell #(
      .SYMBOL_BITS(SYMBOL_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (cell_op),
      .taps  (taps),
      .mul_in(mul_in),
      .s_in  (s_from_below),
      .g_in  (g_from_above),
      .s_out (s_w[c]),
      .g_out (g_w[c])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_BUILD: begin
        if (step_cnt_r == par_last) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (in_fire && msg_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free && (step_cnt_r == par_last)) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_BUILD;
      end
    endcase
    if (cfg_hit) begin
      state_nxt = ST_BUILD;
    end
  end

  // outputs of the sequencer
  always_comb begin
    cell_op      = CELL_HOLD;
    mul_in       = root_r;
    in_ready_c   = 1'b0;
    out_load     = 1'b0;
    out_sym_d    = s_top;
    out_par_d    = 1'b0;
    out_end_d    = 1'b0;
    step_cnt_nxt = step_cnt_r;
    root_nxt     = root_r;
    sym_cnt_nxt  = sym_cnt_r;
    if (cfg_hit) begin
      // abort the block, rebuild the generator from scratch
      cell_op      = CELL_CLEAR;
      step_cnt_nxt = '0;
      root_nxt     = ALPHA;
      sym_cnt_nxt  = '0;
    end else begin
      case (state_r)
        ST_BUILD: begin
          // multiply the partial generator by (x + root)
          cell_op      = CELL_GEN;
          mul_in       = root_r;
          root_nxt     = root_times_x;
          step_cnt_nxt = (step_cnt_r == par_last) ? '0 : step_cnt_r + 1'b1;
        end
        ST_RUN: begin
          in_ready_c = out_free;
          if (in_valid && out_free) begin
            cell_op  = CELL_ENC;
            out_load = 1'b1;
            if (encode_form_r == FORM_SYSTEMATIC) begin
              // division lfsr: echo the symbol, feed back through the top cell
              mul_in    = in_message_symbol ^ s_top;
              out_sym_d = in_message_symbol;
            end else begin
              // transposed fir: the chain accumulates the product
              mul_in    = in_message_symbol;
              out_sym_d = in_message_symbol ^ s_top;
            end
            sym_cnt_nxt  = msg_last ? '0 : sym_cnt_r + 1'b1;
            step_cnt_nxt = '0;
          end
        end
        ST_FLUSH: begin
          // zero feedback: the chain shifts its contents out of the top cell
          if (out_free) begin
            cell_op      = CELL_ENC;
            mul_in       = '0;
            out_load     = 1'b1;
            out_sym_d    = s_top;
            out_par_d    = 1'b1;
            out_end_d    = (step_cnt_r == par_last);
            step_cnt_nxt = (step_cnt_r == par_last) ? '0 : step_cnt_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_poly_r  <= FIELD_POLY_RST;
      correct_cnt_r <= CORRECT_CNT_RST;
      encode_form_r <= ENCODE_FORM_RST;
      state_r       <= ST_BUILD;
      step_cnt_r    <= '0;
      root_r        <= ALPHA;
      sym_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIELD_POLY: begin
            field_poly_r <= cfg_wdata[8:0];
          end
          REG_CORRECT_CNT: begin
            correct_cnt_r <= cfg_wdata[3:0];
          end
          REG_ENCODE_FORM: begin
            encode_form_r <= cfg_wdata[0];
          end
          default: begin
          end
        endcase
      end
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      root_r      <= root_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload, loaded only with a new item
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sym_r <= out_sym_d;
      out_par_r <= out_par_d;
      out_end_r <= out_end_d;
    end
  end

  assign in_ready        = in_ready_c;
  assign out_valid       = out_valid_r;
  assign out_code_symbol = out_sym_r;
  assign out_is_parity   = out_par_r;
  assign out_block_end   = out_end_r;

`ifndef SYNTH
  // no message item may slip in while parity is being flushed
  a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> !in_ready)
    else $error("input accepted during flush");

  // a full flush leaves the chain empty for the next block
  a_chain_empty_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && ($past(state_r) == ST_FLUSH)) |-> (s_top == '0))
    else $error("cell chain not empty after flush");

  // the output register is never overwritten while its item waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output item overwritten");

  // the message counter never passes the block length
  a_count_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (sym_cnt_r < msg_len))
    else $error("message count beyond block length");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import rse_pkg::*;
();

  // the register list has three entries, index 3 must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int NUM_CELLS      = 16;
  localparam int CODE_LEN       = 255;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 250;

  // one codeword item as it should leave the block
  typedef struct packed {
    logic [7:0] sym;
    logic       par;
    logic       blk_end;
  } code_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_message_symbol = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_code_symbol;
  logic                  out_is_parity;
  logic                  out_block_end;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // message items waiting for the driver, codeword items waiting for the monitor
  logic [7:0] message_q[$];
  code_item_t codeword_q[$];

  // encoder state as the predictor sees it
  logic [8:0] fpoly;
  logic [3:0] tcnt;
  logic       eform;
  logic [7:0] gen_c[NUM_CELLS];
  logic [7:0] lfsr_cells[NUM_CELLS];
  int         sym_cnt;

  int  errors = 0;
  int  sent_cnt = 0;
  int  res_cnt = 0;
  int  cfg_cnt = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;

  always #1 clk = ~clk;

  reed_solomon_encoder_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_message_symbol (in_message_symbol),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_symbol   (out_code_symbol),
    .out_is_parity     (out_is_parity),
    .out_block_end     (out_block_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // field multiply, alpha = x, reduction taps from the low byte of the polynomial
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [8:0] sh;
    logic [7:0] r;
    int         i;
    sh = {1'b0, a};
    r  = '0;
    for (i = 0; i < 8; i++) begin
      if (b[i]) r ^= sh[7:0];
      sh = sh << 1;
      if (sh[8]) sh = {1'b0, sh[7:0] ^ fpoly[7:0]};
    end
    return r;
  endfunction

  // 2t after clamping t to 1..8
  function automatic int parity_len();
    int t;
    t = tcnt;
    if (t < 1) t = 1;
    if (t > NUM_CELLS / 2) t = NUM_CELLS / 2;
    return 2 * t;
  endfunction

  function automatic int block_len();
    return CODE_LEN - parity_len();
  endfunction

  // g(x) = prod (x + alpha^i), i = 1..2t; also drops any block in progress
  function automatic void derive_generator();
    logic [7:0] g[NUM_CELLS + 1];
    logic [7:0] root;
    int         p;
    int         i;
    int         j;
    p = parity_len();
    foreach (g[i]) g[i] = '0;
    g[0] = 8'd1;
    root = 8'd1;
    for (i = 1; i <= p; i++) begin
      root = gf_mul(root, 8'd2);
      for (j = i; j >= 1; j--) g[j] = g[j-1] ^ gf_mul(root, g[j]);
      g[0] = gf_mul(root, g[0]);
    end
    for (i = 0; i < NUM_CELLS; i++) begin
      gen_c[i]      = (i < p) ? g[i] : 8'd0;
      lfsr_cells[i] = '0;
    end
    sym_cnt = 0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FIELD_POLY:  fpoly = val[8:0];
      REG_CORRECT_CNT: tcnt  = val[3:0];
      REG_ENCODE_FORM: eform = val[0];
      default: return;
    endcase
    derive_generator();
  endfunction

  function automatic void queue_code(logic [7:0] sym, logic par, logic fin);
    code_item_t c;
    c.sym     = sym;
    c.par     = par;
    c.blk_end = fin;
    codeword_q.insert(codeword_q.size(), c);
  endfunction

  // append at the tail of the pending message items
  function automatic void queue_message(logic [7:0] sym);
    message_q.insert(message_q.size(), sym);
  endfunction

  // transposed fir step of the product form
  function automatic logic [7:0] fir_shift(logic [7:0] u, int p);
    logic [7:0] y;
    int         i;
    y = u;
    for (i = 1; i <= p; i++) y ^= gf_mul(lfsr_cells[i-1], gen_c[p-i]);
    for (i = p - 1; i >= 1; i--) lfsr_cells[i] = lfsr_cells[i-1];
    lfsr_cells[0] = u;
    return y;
  endfunction

  // one accepted message item -> its codeword items
  function automatic void encode_symbol(logic [7:0] u);
    logic [7:0] fb;
    int         p;
    bit         fin;
    int         i;
    p   = parity_len();
    fin = (sym_cnt + 1 >= CODE_LEN - p);
    if (eform == FORM_SYSTEMATIC) begin
      fb = u ^ lfsr_cells[p-1];
      for (i = p - 1; i >= 1; i--) lfsr_cells[i] = lfsr_cells[i-1] ^ gf_mul(fb, gen_c[i]);
      lfsr_cells[0] = gf_mul(fb, gen_c[0]);
      queue_code(u, 1'b0, 1'b0);
      if (fin) begin
        for (i = p; i >= 1; i--) queue_code(lfsr_cells[i-1], 1'b1, i == 1);
      end
    end else begin
      queue_code(fir_shift(u, p), 1'b0, 1'b0);
      if (fin) begin
        for (i = p; i >= 1; i--) queue_code(fir_shift(8'd0, p), 1'b1, i == 1);
      end
    end
    if (fin) begin
      foreach (lfsr_cells[i]) lfsr_cells[i] = '0;
      sym_cnt = 0;
    end else begin
      sym_cnt++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one message item per handshake, random gaps between items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drv
    logic       nv;
    logic [7:0] nsym;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nv   = in_valid;
      nsym = in_message_symbol;
      if (in_valid && in_ready) begin
        encode_symbol(in_message_symbol);
        sent_cnt++;
        nv = 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 19);
      end
      // valid only drops when the current item is taken, so it is never lowered and raised
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (message_q.size() != 0) begin
          nv   = 1'b1;
          nsym = message_q.pop_front();
        end
      end
      in_valid          <= nv;
      in_message_symbol <= nsym;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each codeword item against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d (code item %0d)", what, got, want, res_cnt);
    errors++;
  endtask

  always @(posedge clk) begin : mon
    code_item_t c;
    logic       rdy;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (codeword_q.size() == 0) begin
          report_mismatch("unexpected code item", out_code_symbol, 0);
        end else begin
          c = codeword_q.pop_front();
          if (out_code_symbol !== c.sym) report_mismatch("code_symbol", out_code_symbol, c.sym);
          if (out_is_parity !== c.par) report_mismatch("is_parity", out_is_parity, c.par);
          if (out_block_end !== c.blk_end) report_mismatch("block_end", out_block_end, c.blk_end);
        end
        res_cnt++;
        // long back-pressure mid block so the block fills up and stalls its input
        if (res_cnt == 100) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!calm && $urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 19);
      end
      out_ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any item moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // sampled at the falling edge so every handshake of the cycle has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (message_q.size() != 0 || in_valid || codeword_q.size() != 0);
  endtask

  // pause first: covers the parity flush and any generator build still running
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_cfg(idx, val);
    cfg_cnt++;
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper data bits carry random noise
  task automatic load_settings(logic [8:0] poly, logic [3:0] t, logic form);
    logic [4:0] t_noise;
    logic [7:0] f_noise;
    t_noise = 5'($urandom);
    f_noise = 8'($urandom);
    write_reg(REG_FIELD_POLY, poly);
    write_reg(REG_CORRECT_CNT, {t_noise, t});
    write_reg(REG_ENCODE_FORM, {f_noise, form});
  endtask

  function automatic logic [7:0] rand_symbol();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) queue_message(rand_symbol());
    wait_idle();
  endtask

  logic [7:0] corner_syms[24] = '{
    8'h00, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'hAA, 8'h55, 8'h00, 8'h00, 8'hFF, 8'hFF,
    8'h02, 8'h40, 8'h0F, 8'hF0, 8'h33, 8'hCC,
    8'hFF, 8'h00, 8'h01, 8'h80, 8'h5A, 8'hA5
  };

  initial begin
    logic [7:0] noise;
    int         i;

    // registers and generator as after reset
    fpoly = FIELD_POLY_RST;
    tcnt  = CORRECT_CNT_RST;
    eform = ENCODE_FORM_RST;
    derive_generator();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // t = 15 is taken as 8, so the block keeps its reset geometry
    noise = 8'($urandom);
    write_reg(REG_CORRECT_CNT, {noise[4:0], 4'd15});

    // directed: field extremes in systematic form, block left open
    for (i = 0; i < 12; i++) queue_message(corner_syms[i]);
    wait_idle();

    // write beyond the register list: block must carry on untouched
    noise = 8'($urandom);
    write_reg(REG_UNUSED, {1'b1, noise});
    for (i = 12; i < 18; i++) queue_message(corner_syms[i]);
    wait_idle();

    // rest of the block with random symbols, then the parity flush
    send_random(block_len() - 18);

    // product form, a short block that the next writes abort
    noise = 8'($urandom);
    write_reg(REG_ENCODE_FORM, {noise, FORM_PRODUCT});
    for (i = 18; i < 24; i++) queue_message(corner_syms[i]);
    wait_idle();

    // last stretch without any idling: highest polynomial, t = 0 taken as 1
    calm = 1'b1;
    load_settings(9'd511, 4'd0, FORM_PRODUCT);
    send_random(40);

    wait_idle();
    repeat (40) @(posedge clk);
    if (codeword_q.size() != 0) report_mismatch("code items never seen", codeword_q.size(), 0);

    $display("%0d message items in, %0d code items checked, %0d register writes",
             sent_cnt, res_cnt, cfg_cnt);
    $display("a full systematic codeword with parity, product form, t clamped from 15 and 0, aborts");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
